@@ hw/rtl/icpe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icpe_pkg
// Shared types and constants of the indexed color palette expander.
// ----------------------------------------------------------------------------
package icpe_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 32;
  localparam int IDX_W           = 8;
  localparam int NIB_W           = 4;
  localparam int SMALL_ENTRIES   = 16;

  localparam logic [IDX_W:0] ENTRIES_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);
  localparam logic [IDX_W:0] SMALL_LIM   = (IDX_W + 1)'(SMALL_ENTRIES);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_W   = PADDR_W - 2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_EXPAND = 1'b1
  } op_e;

  typedef enum logic {
    MODE_256 = 1'b0,
    MODE_16  = 1'b1
  } mode_e;

  typedef enum logic [REG_W-1:0] {
    REG_PALETTE_MODE = 1'b0
  } reg_e;

  typedef struct packed {
    logic               last;
    logic [COLOR_W-1:0] color;
  } out_item_t;

  function automatic logic [IDX_W-1:0] unswizzle(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] r;
    r    = pos;
    r[4] = pos[3];
    r[3] = pos[4];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/indexed_color_palette_expander_core.sv @@
`default_nettype none
// A read item's first pixel passes the registered palette read, then the output queue.
// Throughput: 1 item per cycle for palette writes and single-pixel bytes while the
// output queue has room; a packed 16-entry byte holds the input stalled while its high
// nibble is read, set by the single read port of the palette RAM.
// Reset: palette mode returns to 256 entries; palette contents stay undefined
// until written, there is no clearing pass.
// ----------------------------------------------------------------------------
// indexed_color_palette_expander_core
// Expands palette-indexed bytes to 32-bit colors via a palette RAM.
// ----------------------------------------------------------------------------
module indexed_color_palette_expander_core
  import icpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               in_operation_i,
  input  wire logic [IDX_W-1:0]   in_entry_position_i,
  input  wire logic [COLOR_W-1:0] in_entry_color_i,
  input  wire logic [IDX_W-1:0]   in_index_byte_i,
  input  wire logic               in_low_nibble_only_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [COLOR_W-1:0] out_pixel_color_o,
  output      logic               out_last_of_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  mode_e mode;

  icpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  // issue control
  logic             in_acc, space, hi_issue;
  logic             hi_pend_q, hi_pend_d;
  logic [NIB_W-1:0] hi_idx_q, hi_idx_d;
  logic             rd_vld_q, rd_last_q, rd_zero_q;
  logic             re, re_last, re_zero;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_target;
  logic             we;
  logic [COLOR_W-1:0] rdata;
  logic             pop, push;

  // output queue
  out_item_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  out_item_t          push_item;

  assign space      = (cnt_q + CNT_W'(rd_vld_q)) < CNT_W'(FIFO_DEPTH);
  assign in_stall_o = hi_pend_q | ~space;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign hi_issue   = hi_pend_q & space;

  // palette write
  always_comb begin
    wr_target = in_entry_position_i;
    we        = 1'b0;
    if (mode == MODE_256) begin
      wr_target = unswizzle(in_entry_position_i);
      we        = 1'b1;
    end else begin
      we = ({1'b0, in_entry_position_i} < SMALL_LIM);
    end
    we = we & in_acc & (in_operation_i == OP_WRITE)
         & ({1'b0, wr_target} < ENTRIES_LIM);
  end

  // palette read issue
  always_comb begin
    re        = 1'b0;
    re_last   = 1'b1;
    rd_idx    = in_index_byte_i;
    hi_pend_d = hi_pend_q;
    hi_idx_d  = hi_idx_q;
    if (hi_issue) begin
      re        = 1'b1;
      rd_idx    = IDX_W'(hi_idx_q);
      hi_pend_d = 1'b0;
    end else if (in_acc && in_operation_i == OP_EXPAND) begin
      re = 1'b1;
      if (mode == MODE_16) begin
        rd_idx  = IDX_W'(in_index_byte_i[NIB_W-1:0]);
        re_last = in_low_nibble_only_i;
        if (!in_low_nibble_only_i) begin
          hi_pend_d = 1'b1;
          hi_idx_d  = in_index_byte_i[IDX_W-1:NIB_W];
        end
      end
    end
  end

  assign re_zero = ~({1'b0, rd_idx} < ENTRIES_LIM);

  icpe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_target[PAL_AW-1:0]),
    .wdata_i (in_entry_color_i),
    .re_i    (re),
    .raddr_i (rd_idx[PAL_AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_pend_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      hi_pend_q <= hi_pend_d;
      rd_vld_q  <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_idx_q <= hi_idx_d;
    if (re) begin
      rd_last_q <= re_last;
      rd_zero_q <= re_zero;
    end
  end

  assign push            = rd_vld_q;
  assign pop             = out_valid_o & ~out_stall_i;
  assign push_item.last  = rd_last_q;
  assign push_item.color = rd_zero_q ? '0 : rdata;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign out_valid_o        = (cnt_q != '0);
  assign out_pixel_color_o  = fifo_q[rd_ptr_q].color;
  assign out_last_of_item_o = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_hi_only_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_pend_q |-> mode == MODE_16)
    else $error("high nibble pending outside 16-entry mode");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> cnt_q < CNT_W'(FIFO_DEPTH))
    else $error("read data arrives with output queue full");

  a_hi_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_issue |=> rd_vld_q && rd_last_q)
    else $error("high nibble pixel not marked last");

  a_pair_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hi_pend_q) |-> rd_vld_q && !rd_last_q)
    else $error("first pixel of a packed byte marked last");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/icpe_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icpe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module icpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/icpe_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icpe_cfg
// APB register file holding the palette mode.
// ----------------------------------------------------------------------------
module icpe_cfg
  import icpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      mode_e              mode_o
);

  mode_e            mode_q, mode_d;
  logic [REG_W-1:0] reg_sel;
  logic             wr_en;

  assign reg_sel = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (wr_en && reg_sel == REG_PALETTE_MODE) begin
      mode_d = mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_256;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_PALETTE_MODE: prdata = PDATA_W'(mode_q);
      default:          prdata = '0;
    endcase
  end

  assign mode_o = mode_q;

endmodule
`default_nettype wire
